[rtl/lllq_pkg.sv]
// ---------------------------------------------------------------------------
// Linked list queue manager package
// Shared widths, operation and status codes, and the result record.
// ---------------------------------------------------------------------------
package lllq_pkg;

   localparam int DEFAULT_ENTRIES = 256;
   localparam int MAX_SLOTS       = 256;

   localparam int OPCODE_W = 3;
   localparam int ENTRY_W  = 8;
   localparam int COUNT_W  = 9;
   localparam int STATUS_W = 2;

   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 40;

   localparam logic [OPCODE_W-1:0] OP_INSERT       = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_INSERT_GROUP = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_REMOVE_HEAD  = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_PRESENT      = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_UNLINK       = 3'd4;

   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd2;
   localparam logic [STATUS_W-1:0] ST_DUPLICATE = 2'd3;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ENTRY_W-1:0]  removed_entry;
      logic                found;
      logic [COUNT_W-1:0]  queue_count;
      logic [ENTRY_W-1:0]  head_entry;
      logic [ENTRY_W-1:0]  tail_entry;
      logic                is_empty;
   } lllq_result_type;

endpackage

[rtl/lllq_link_ram.sv]
// ---------------------------------------------------------------------------
// Link table memory
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module lllq_link_ram #(
   parameter int DEPTH  = lllq_pkg::MAX_SLOTS,
   parameter int ADDR_W = 8
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [ADDR_W-1:0]            wr_addr,
   input  logic [lllq_pkg::ENTRY_W-1:0] wr_data,
   input  logic                         rd_en,
   input  logic [ADDR_W-1:0]            rd_addr,
   output logic [lllq_pkg::ENTRY_W-1:0] rd_data
);
   import lllq_pkg::*;

   logic [ENTRY_W-1:0] mem [DEPTH];
   logic [ENTRY_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/lllq_engine.sv]
// ---------------------------------------------------------------------------
// Queue engine
// Sequencer that runs each operation over the link table, membership bits
// and head, tail and count registers, one step per cycle while it runs, holding the result until it is acknowledged.
// ---------------------------------------------------------------------------
module lllq_engine #(
   parameter int ENTRIES = lllq_pkg::DEFAULT_ENTRIES
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [lllq_pkg::OPCODE_W-1:0] opcode,
   input  logic [lllq_pkg::ENTRY_W-1:0]  entry,
   input  logic [lllq_pkg::COUNT_W-1:0]  group_count,
   output logic                          idle,
   output logic                          done,
   input  logic                          ack,
   output lllq_pkg::lllq_result_type     result
);
   import lllq_pkg::*;

   localparam int SLOTS = (ENTRIES < MAX_SLOTS) ? ENTRIES : MAX_SLOTS;
   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam logic [COUNT_W:0] LIMIT = (COUNT_W + 1)'(SLOTS);

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_GROUP_CHECK,
      S_GROUP_APPEND,
      S_REMOVE,
      S_WALK_CMP,
      S_WALK_LOAD,
      S_UNLINK,
      S_RESPOND
   } state_type;

   state_type           state_ff, state_in;
   logic [COUNT_W-1:0]  total_ff, total_in;
   logic [ENTRY_W-1:0]  head_ff, head_in;
   logic [ENTRY_W-1:0]  tail_ff, tail_in;
   logic                mark_ff [SLOTS];
   logic                mark_in [SLOTS];

   logic [OPCODE_W-1:0] op_ff, op_in;
   logic [ENTRY_W-1:0]  entry_ff, entry_in;
   logic [COUNT_W-1:0]  grp_n_ff, grp_n_in;
   logic [COUNT_W-1:0]  step_ff, step_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [ENTRY_W-1:0]  removed_ff, removed_in;
   logic                found_ff, found_in;
   logic [ENTRY_W-1:0]  cur_ff, cur_in;
   logic [ENTRY_W-1:0]  prev_ff, prev_in;
   logic                has_prev_ff, has_prev_in;

   logic                ram_wr_en;
   logic [IDX_W-1:0]    ram_wr_addr;
   logic [ENTRY_W-1:0]  ram_wr_data;
   logic                ram_rd_en;
   logic [IDX_W-1:0]    ram_rd_addr;
   logic [ENTRY_W-1:0]  ram_rd_data;

   logic [ENTRY_W-1:0]  pos;
   logic [COUNT_W:0]    group_end;
   logic                entry_ok;
   logic                entry_marked;
   logic                last_step;

   lllq_link_ram #(
      .DEPTH  (SLOTS),
      .ADDR_W (IDX_W)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign pos          = entry_ff + step_ff[ENTRY_W-1:0];
   assign group_end    = {2'b00, entry_ff} + {1'b0, grp_n_ff};
   assign entry_ok     = {2'b00, entry_ff} < LIMIT;
   assign entry_marked = mark_ff[entry_ff[IDX_W-1:0]];
   assign last_step    = (step_ff + COUNT_W'(1)) == grp_n_ff;

   always_comb begin
      state_in    = state_ff;
      total_in    = total_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      mark_in     = mark_ff;
      op_in       = op_ff;
      entry_in    = entry_ff;
      grp_n_in    = grp_n_ff;
      step_in     = step_ff;
      status_in   = status_ff;
      removed_in  = removed_ff;
      found_in    = found_ff;
      cur_in      = cur_ff;
      prev_in     = prev_ff;
      has_prev_in = has_prev_ff;
      ram_wr_en   = 1'b0;
      ram_wr_addr = tail_ff[IDX_W-1:0];
      ram_wr_data = pos;
      ram_rd_en   = 1'b0;
      ram_rd_addr = head_ff[IDX_W-1:0];

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in      = opcode;
               entry_in   = entry;
               grp_n_in   = group_count;
               step_in    = '0;
               status_in  = ST_OK;
               removed_in = '0;
               found_in   = 1'b0;
               state_in   = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in = S_RESPOND;
            case (op_ff)
               OP_INSERT: begin
                  if (!entry_ok) begin
                     status_in = ST_RANGE;
                  end else if (entry_marked) begin
                     status_in = ST_DUPLICATE;
                  end else begin
                     if (total_ff == '0) begin
                        head_in = pos;
                     end else begin
                        ram_wr_en = 1'b1;
                     end
                     tail_in              = pos;
                     mark_in[pos[IDX_W-1:0]] = 1'b1;
                     total_in             = total_ff + COUNT_W'(1);
                  end
               end
               OP_INSERT_GROUP: begin
                  if (grp_n_ff != '0) begin
                     if (group_end > LIMIT) begin
                        status_in = ST_RANGE;
                     end else begin
                        state_in = S_GROUP_CHECK;
                     end
                  end
               end
               OP_REMOVE_HEAD: begin
                  if (total_ff == '0) begin
                     status_in = ST_EMPTY;
                  end else begin
                     removed_in = head_ff;
                     ram_rd_en  = 1'b1;
                     state_in   = S_REMOVE;
                  end
               end
               OP_PRESENT: begin
                  found_in = entry_ok && entry_marked;
               end
               OP_UNLINK: begin
                  if (entry_ok && entry_marked) begin
                     found_in    = 1'b1;
                     cur_in      = head_ff;
                     has_prev_in = 1'b0;
                     state_in    = S_WALK_CMP;
                  end
               end
               default: begin
                  state_in = S_RESPOND;
               end
            endcase
         end
         S_GROUP_CHECK: begin
            if (mark_ff[pos[IDX_W-1:0]]) begin
               status_in = ST_DUPLICATE;
               state_in  = S_RESPOND;
            end else if (last_step) begin
               step_in  = '0;
               state_in = S_GROUP_APPEND;
            end else begin
               step_in = step_ff + COUNT_W'(1);
            end
         end
         S_GROUP_APPEND: begin
            if (total_ff == '0) begin
               head_in = pos;
            end else begin
               ram_wr_en = 1'b1;
            end
            tail_in                 = pos;
            mark_in[pos[IDX_W-1:0]] = 1'b1;
            total_in                = total_ff + COUNT_W'(1);
            if (last_step) begin
               state_in = S_RESPOND;
            end else begin
               step_in = step_ff + COUNT_W'(1);
            end
         end
         S_REMOVE: begin
            if (total_ff > COUNT_W'(1)) begin
               head_in = ram_rd_data;
            end else begin
               head_in = '0;
               tail_in = '0;
            end
            mark_in[removed_ff[IDX_W-1:0]] = 1'b0;
            total_in = total_ff - COUNT_W'(1);
            state_in = S_RESPOND;
         end
         S_WALK_CMP: begin
            ram_rd_en = 1'b1;
            if (cur_ff == entry_ff) begin
               ram_rd_addr = entry_ff[IDX_W-1:0];
               state_in    = S_UNLINK;
            end else begin
               ram_rd_addr = cur_ff[IDX_W-1:0];
               prev_in     = cur_ff;
               has_prev_in = 1'b1;
               state_in    = S_WALK_LOAD;
            end
         end
         S_WALK_LOAD: begin
            cur_in   = ram_rd_data;
            state_in = S_WALK_CMP;
         end
         S_UNLINK: begin
            if (!has_prev_ff) begin
               head_in = ram_rd_data;
            end else if (entry_ff == tail_ff) begin
               tail_in = prev_ff;
            end else begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = prev_ff[IDX_W-1:0];
               ram_wr_data = ram_rd_data;
            end
            if (total_ff == COUNT_W'(1)) begin
               head_in = '0;
               tail_in = '0;
            end
            mark_in[entry_ff[IDX_W-1:0]] = 1'b0;
            total_in = total_ff - COUNT_W'(1);
            state_in = S_RESPOND;
         end
         S_RESPOND: begin
            if (ack) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         total_ff <= '0;
         head_ff  <= '0;
         tail_ff  <= '0;
         for (int i = 0; i < SLOTS; i++) begin
            mark_ff[i] <= 1'b0;
         end
      end else begin
         state_ff <= state_in;
         total_ff <= total_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         mark_ff  <= mark_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      entry_ff    <= entry_in;
      grp_n_ff    <= grp_n_in;
      step_ff     <= step_in;
      status_ff   <= status_in;
      removed_ff  <= removed_in;
      found_ff    <= found_in;
      cur_ff      <= cur_in;
      prev_ff     <= prev_in;
      has_prev_ff <= has_prev_in;
   end

   assign idle = (state_ff == S_IDLE);
   assign done = (state_ff == S_RESPOND);

   always_comb begin
      result.status        = status_ff;
      result.removed_entry = removed_ff;
      result.found         = found_ff;
      result.queue_count   = total_ff;
      result.head_entry    = (total_ff != '0) ? head_ff : '0;
      result.tail_entry    = (total_ff != '0) ? tail_ff : '0;
      result.is_empty      = (total_ff == '0);
   end

endmodule

[rtl/linked_list_queue_manager_top.sv]
// ---------------------------------------------------------------------------
// Linked list queue manager
// Singly linked queue of entry indices kept in a link table, with a
// membership bit per entry and one result beat for every request beat.
//
//   Channel   Direction   Beat contents
//   req_      in          opcode, entry, group_count
//   rsp_      out         status, removed_entry, found, queue_count,
//                         head_entry, tail_entry, is_empty
//
// Insert and present test answer from the decode step, and remove head adds
// one read of the link table. A group insert checks every entry of the group
// and then appends them, one entry per cycle. Unlink walks the list from the
// head to the entry; each hop is one read of the link table port. Reset is
// synchronous and clears the queue and all membership bits at once. The
// result register holds a beat under rsp_tready low while the next request
// is taken.
// ---------------------------------------------------------------------------
module linked_list_queue_manager_top #(
   parameter int ENTRIES = lllq_pkg::DEFAULT_ENTRIES
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // opcode [2:0], entry [10:3], group_count [19:11], zero fill [23:20]
   input  logic [lllq_pkg::REQ_TDATA_W-1:0] req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // status [1:0], removed_entry [9:2], found [10], queue_count [19:11],
   // head_entry [27:20], tail_entry [35:28], is_empty [36], zero fill [39:37]
   output logic [lllq_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import lllq_pkg::*;

   logic                   eng_idle;
   logic                   eng_done;
   logic                   eng_ack;
   logic                   start;
   lllq_result_type        eng_result;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   assign req_tready = eng_idle;
   assign start      = req_tvalid && eng_idle;
   assign eng_ack    = eng_done && (!rsp_valid_ff || rsp_tready);

   lllq_engine #(
      .ENTRIES (ENTRIES)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .opcode      (req_tdata[2:0]),
      .entry       (req_tdata[10:3]),
      .group_count (req_tdata[19:11]),
      .idle        (eng_idle),
      .done        (eng_done),
      .ack         (eng_ack),
      .result      (eng_result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (eng_ack) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {3'b000,
                         eng_result.is_empty,
                         eng_result.tail_entry,
                         eng_result.head_entry,
                         eng_result.queue_count,
                         eng_result.found,
                         eng_result.removed_entry,
                         eng_result.status};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

[tb/linked_list_queue_manager_top_test.sv]
// ---------------------------------------------------------------------------
// Linked list queue manager testbench
// Drives insert, group insert, remove, present, unlink and reserved opcode
// requests through the request stream and checks every response beat against
// a behavioral queue kept alongside, with random gaps and stalls on both streams.
// ---------------------------------------------------------------------------
module linked_list_queue_manager_top_test;
   import lllq_pkg::*;

   localparam int ENTRY_LIMIT     = 256;
   localparam int RANDOM_REQUESTS = 900;
   localparam int QUIET_TAIL      = 100;
   localparam int STUCK_LIMIT     = 5000;
   localparam int DRAIN_CYCLES    = 40;
   localparam int REPORT_LIMIT    = 40;

   localparam logic [OPCODE_W-1:0] OP_RESERVED_FIRST = 3'd5;

   typedef struct packed {
      logic [OPCODE_W-1:0] opcode;
      logic [ENTRY_W-1:0]  entry;
      logic [COUNT_W-1:0]  group_count;
   } queue_request_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   queue_request_type request_backlog[$];
   lllq_result_type   awaited_results[$];
   queue_request_type in_flight;
   lllq_result_type   want;

   bit [ENTRY_W-1:0] link_of [ENTRY_LIMIT];
   bit               held    [ENTRY_LIMIT];
   bit [ENTRY_W-1:0] head_at;
   bit [ENTRY_W-1:0] tail_at;
   int unsigned      held_total;

   int planned_count   = 0;
   int accepted_count  = 0;
   int results_checked = 0;
   int mismatch_count  = 0;
   int stuck_cycles    = 0;
   int send_hold       = 0;
   int recv_hold       = 0;
   int op_tally     [8];
   int status_tally [4];
   int found_tally     = 0;

   linked_list_queue_manager_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #4 clock = ~clock;

   task automatic add_request(input logic [OPCODE_W-1:0] op, input int e, input int n);
      queue_request_type rq;
      rq.opcode      = op;
      rq.entry       = ENTRY_W'(e);
      rq.group_count = COUNT_W'(n);
      request_backlog.push_back(rq);
      planned_count++;
   endtask

   function automatic void link_append(input bit [ENTRY_W-1:0] e);
      if (held_total == 0) begin
         head_at = e;
      end else begin
         link_of[tail_at] = e;
      end
      tail_at = e;
      held[e] = 1'b1;
      held_total++;
   endfunction

   function automatic void link_drop(input bit [ENTRY_W-1:0] e);
      held[e] = 1'b0;
      held_total--;
      if (held_total == 0) begin
         head_at = '0;
         tail_at = '0;
      end
   endfunction

   function automatic lllq_result_type queue_outcome(input queue_request_type rq);
      lllq_result_type r;
      int               e;
      int               n;
      int               i;
      bit [ENTRY_W-1:0] cur;
      bit [ENTRY_W-1:0] prev;
      bit               has_prev;
      e = int'(rq.entry);
      n = int'(rq.group_count);
      r = '0;
      r.status = ST_OK;
      case (rq.opcode)
         OP_INSERT: begin
            if (e >= ENTRY_LIMIT) begin
               r.status = ST_RANGE;
            end else if (held[e]) begin
               r.status = ST_DUPLICATE;
            end else begin
               link_append(ENTRY_W'(e));
            end
         end
         OP_INSERT_GROUP: begin
            if (n != 0) begin
               if (e + n > ENTRY_LIMIT) begin
                  r.status = ST_RANGE;
               end else begin
                  for (i = 0; i < n; i++) begin
                     if (held[e + i]) r.status = ST_DUPLICATE;
                  end
                  if (r.status == ST_OK) begin
                     for (i = 0; i < n; i++) link_append(ENTRY_W'(e + i));
                  end
               end
            end
         end
         OP_REMOVE_HEAD: begin
            if (held_total == 0) begin
               r.status = ST_EMPTY;
            end else begin
               r.removed_entry = head_at;
               cur = head_at;
               if (held_total > 1) head_at = link_of[cur];
               link_drop(cur);
            end
         end
         OP_PRESENT: begin
            r.found = held[e];
         end
         OP_UNLINK: begin
            if (held[e]) begin
               r.found = 1'b1;
               cur = head_at;
               prev = '0;
               has_prev = 1'b0;
               for (i = 0; i < held_total && cur != ENTRY_W'(e); i++) begin
                  prev = cur;
                  has_prev = 1'b1;
                  cur = link_of[cur];
               end
               if (!has_prev) begin
                  if (held_total > 1) head_at = link_of[e];
               end else if (ENTRY_W'(e) == tail_at) begin
                  tail_at = prev;
               end else begin
                  link_of[prev] = link_of[e];
               end
               link_drop(ENTRY_W'(e));
            end
         end
         default: begin
         end
      endcase
      r.queue_count = COUNT_W'(held_total);
      r.head_entry  = (held_total != 0) ? head_at : '0;
      r.tail_entry  = (held_total != 0) ? tail_at : '0;
      r.is_empty    = (held_total == 0);
      op_tally[rq.opcode]++;
      status_tally[r.status]++;
      if (r.found) found_tally++;
      return r;
   endfunction

   task automatic check_field(input string label, input int unsigned expected_value,
                              input int unsigned actual_value);
      if (expected_value != actual_value) begin
         mismatch_count++;
         if (mismatch_count <= REPORT_LIMIT) begin
            $display("%0t: response %0d %s mismatch: expected %0d, actual %0d",
                     $time, results_checked, label, expected_value, actual_value);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         send_hold  = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            awaited_results.push_back(queue_outcome(in_flight));
            accepted_count++;
         end
         if (!req_tvalid || req_tready) begin
            if (send_hold != 0) begin
               send_hold = send_hold - 1;
               req_tvalid <= 1'b0;
            end else if (accepted_count + QUIET_TAIL < planned_count
                         && (accepted_count / 70) % 3 != 2
                         && $urandom_range(0, 7) == 0) begin
               send_hold = $urandom_range(0, 14);
               req_tvalid <= 1'b0;
            end else if (request_backlog.size() != 0) begin
               in_flight = request_backlog.pop_front();
               req_tdata <= {4'b0, in_flight.group_count, in_flight.entry, in_flight.opcode};
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_hold  = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (awaited_results.size() == 0) begin
               mismatch_count++;
               $display("%0t: response beat with no request pending: expected none, actual %h",
                        $time, rsp_tdata);
            end else begin
               want = awaited_results.pop_front();
               check_field("status",        32'(want.status),        32'(rsp_tdata[1:0]));
               check_field("removed_entry", 32'(want.removed_entry), 32'(rsp_tdata[9:2]));
               check_field("found",         32'(want.found),         32'(rsp_tdata[10]));
               check_field("queue_count",   32'(want.queue_count),   32'(rsp_tdata[19:11]));
               check_field("head_entry",    32'(want.head_entry),    32'(rsp_tdata[27:20]));
               check_field("tail_entry",    32'(want.tail_entry),    32'(rsp_tdata[35:28]));
               check_field("is_empty",      32'(want.is_empty),      32'(rsp_tdata[36]));
            end
            results_checked++;
         end
         if (recv_hold != 0) begin
            recv_hold = recv_hold - 1;
            rsp_tready <= 1'b0;
         end else if (results_checked + QUIET_TAIL < planned_count
                      && (results_checked / 80) % 3 != 1
                      && $urandom_range(0, 11) == 0) begin
            recv_hold = $urandom_range(0, 14);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            stuck_cycles <= 0;
         end else if (stuck_cycles >= STUCK_LIMIT) begin
            $display("Timeout: no beat moved for %0d cycles.", STUCK_LIMIT);
            $display("** linked_list_queue_manager_top: FAILED **");
            $finish;
         end else begin
            stuck_cycles <= stuck_cycles + 1;
         end
      end
   end

   initial begin
      int k;
      int phase;
      int pick;
      int pool_base;
      int e;
      int n;
      int c_ins;
      int c_grp;
      int c_rem;
      int c_pres;
      int c_unl;
      for (k = 0; k < ENTRY_LIMIT; k++) begin
         link_of[k] = '0;
         held[k] = 1'b0;
      end
      head_at = '0;
      tail_at = '0;
      held_total = 0;
      pool_base = 0;

      add_request(OP_REMOVE_HEAD, 0, 0);
      add_request(OP_PRESENT, 0, 511);
      add_request(OP_UNLINK, 255, 0);
      add_request(OP_INSERT, 0, 0);
      add_request(OP_INSERT, 255, 511);
      add_request(OP_INSERT, 0, 0);
      add_request(OP_INSERT_GROUP, 10, 0);
      add_request(OP_INSERT_GROUP, 250, 6);
      add_request(OP_INSERT_GROUP, 250, 7);
      add_request(OP_INSERT_GROUP, 1, 511);
      add_request(OP_INSERT_GROUP, 100, 5);
      add_request(OP_PRESENT, 102, 0);
      add_request(OP_UNLINK, 0, 0);
      add_request(OP_UNLINK, 102, 0);
      add_request(OP_UNLINK, 104, 0);
      add_request(OP_UNLINK, 255, 0);
      for (k = 0; k < 3; k++) begin
         add_request(OPCODE_W'(OP_RESERVED_FIRST + k), 255 - k * 60, 511 - k * 100);
      end
      for (k = 0; k < 4; k++) add_request(OP_REMOVE_HEAD, 0, 0);
      add_request(OP_INSERT_GROUP, 0, 256);
      add_request(OP_INSERT, 77, 0);
      add_request(OP_UNLINK, 255, 0);
      add_request(OP_PRESENT, 128, 0);

      for (k = 0; k < RANDOM_REQUESTS; k++) begin
         if (k % 100 == 0) pool_base = $urandom_range(0, 208);
         phase = ((k / 150) + 2) % 3;
         case (phase)
            0: begin c_ins = 40; c_grp = 55; c_rem = 70; c_pres = 83; c_unl = 97; end
            1: begin c_ins = 25; c_grp = 33; c_rem = 58; c_pres = 78; c_unl = 98; end
            default: begin c_ins = 6; c_grp = 9; c_rem = 74; c_pres = 84; c_unl = 98; end
         endcase
         pick = $urandom_range(0, 99);
         e = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                         : pool_base + $urandom_range(0, 47);
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
         if (pick < c_ins) begin
            add_request(OP_INSERT, e, $urandom_range(0, 511));
         end else if (pick < c_grp) begin
            add_request(OP_INSERT_GROUP, e, n);
         end else if (pick < c_rem) begin
            add_request(OP_REMOVE_HEAD, $urandom_range(0, 255), $urandom_range(0, 511));
         end else if (pick < c_pres) begin
            add_request(OP_PRESENT, e, $urandom_range(0, 511));
         end else if (pick < c_unl) begin
            add_request(OP_UNLINK, e, $urandom_range(0, 511));
         end else begin
            case ($urandom_range(0, 2))
               0: add_request(OPCODE_W'(OP_RESERVED_FIRST + $urandom_range(0, 2)), e,
                              $urandom_range(0, 511));
               1: add_request(OP_INSERT_GROUP, e, $urandom_range(257, 511));
               default: add_request(OP_INSERT_GROUP, e, 0);
            endcase
         end
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (results_checked < planned_count || awaited_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d requests: %0d insert, %0d group insert, %0d remove,",
               accepted_count, op_tally[OP_INSERT], op_tally[OP_INSERT_GROUP],
               op_tally[OP_REMOVE_HEAD]);
      $display("%0d present, %0d unlink, %0d reserved.",
               op_tally[OP_PRESENT], op_tally[OP_UNLINK],
               accepted_count - op_tally[OP_INSERT] - op_tally[OP_INSERT_GROUP]
               - op_tally[OP_REMOVE_HEAD] - op_tally[OP_PRESENT] - op_tally[OP_UNLINK]);
      $display("Statuses: %0d ok, %0d empty, %0d range, %0d duplicate; %0d hits; %0d checked.",
               status_tally[ST_OK], status_tally[ST_EMPTY], status_tally[ST_RANGE],
               status_tally[ST_DUPLICATE], found_tally, results_checked);
      if (mismatch_count == 0 && results_checked == accepted_count) begin
         $display("** linked_list_queue_manager_top: PASSED **");
      end else begin
         $display("** linked_list_queue_manager_top: FAILED **");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/lllq_pkg.sv
rtl/lllq_link_ram.sv
rtl/lllq_engine.sv
rtl/linked_list_queue_manager_top.sv
tb/linked_list_queue_manager_top_test.sv
